FILE: hw/rtl/rlcc_pkg.sv
`timescale 1ns / 1ps
package rlcc_pkg;

   // Number of decimal digits in the run count.
   localparam int COUNT_DIGITS = 5;
   localparam int CNT_W = 4 * COUNT_DIGITS;
   localparam int IDX_W = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

   localparam int CHAR_W = 8;
   localparam int LEN_W = 16;

   // Depth of the queue between the front and the back.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // One closing request: an optional run closed by a change of character
   // or a full count, then an optional final run that ends the stream.
   typedef struct packed {
      logic              a_valid;
      logic [CHAR_W-1:0] a_sym;
      logic [CNT_W-1:0]  a_cnt;
      logic              b_valid;
      logic [CHAR_W-1:0] b_sym;
      logic [CNT_W-1:0]  b_cnt;
   } close_rec_type;

   typedef enum logic [0:0] {
      PH_SYM,
      PH_DIGIT
   } phase_type;

endpackage

FILE: hw/rtl/rlcc_front.sv
`timescale 1ns / 1ps
module rlcc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic [rlcc_pkg::CHAR_W-1:0]   req_char,
   input  logic                          req_last,
   input  logic                          q_full,
   output logic                          q_push,
   output rlcc_pkg::close_rec_type       q_rec
);
   import rlcc_pkg::*;

   logic [CHAR_W-1:0] run_sym_ff, run_sym_in;
   logic [CNT_W-1:0]  run_cnt_ff, run_cnt_in;
   logic              run_open_ff, run_open_in;

   logic              accept;
   logic              cnt_full;
   logic              cont;
   logic              close_a;
   logic [CNT_W-1:0]  cnt_inc;
   logic [CNT_W-1:0]  new_cnt;

   function automatic logic bcd_all_nines(input logic [CNT_W-1:0] cnt);
      logic res;
      res = 1'b1;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (cnt[4*i +: 4] != 4'd9) begin
            res = 1'b0;
         end
      end
      return res;
   endfunction

   function automatic logic [CNT_W-1:0] bcd_plus_one(input logic [CNT_W-1:0] cnt);
      logic [CNT_W-1:0] res;
      logic             carry;
      logic [3:0]       d;
      res = cnt;
      carry = 1'b1;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         d = cnt[4*i +: 4];
         if (carry) begin
            if (d == 4'd9) begin
               res[4*i +: 4] = 4'd0;
            end else begin
               res[4*i +: 4] = d + 4'd1;
               carry = 1'b0;
            end
         end
      end
      return res;
   endfunction

   always_comb begin
      accept   = req_push && !q_full;
      cnt_full = bcd_all_nines(run_cnt_ff);
      cnt_inc  = bcd_plus_one(run_cnt_ff);
      cont     = run_open_ff && (run_sym_ff == req_char) && !cnt_full;
      close_a  = run_open_ff && !cont;
      new_cnt  = cont ? cnt_inc : CNT_ONE;

      q_rec.a_valid = close_a;
      q_rec.a_sym   = run_sym_ff;
      q_rec.a_cnt   = run_cnt_ff;
      q_rec.b_valid = req_last;
      q_rec.b_sym   = req_char;
      q_rec.b_cnt   = new_cnt;
      q_push        = accept && (close_a || req_last);

      run_sym_in  = run_sym_ff;
      run_cnt_in  = run_cnt_ff;
      run_open_in = run_open_ff;
      if (accept) begin
         run_sym_in  = req_char;
         run_cnt_in  = new_cnt;
         run_open_in = !req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff <= 1'b0;
         run_sym_ff  <= '0;
         run_cnt_ff  <= '0;
      end else begin
         run_open_ff <= run_open_in;
         run_sym_ff  <= run_sym_in;
         run_cnt_ff  <= run_cnt_in;
      end
   end

endmodule

FILE: hw/rtl/rlcc_queue.sv
`timescale 1ns / 1ps
module rlcc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rlcc_pkg::close_rec_type push_rec,
   input  logic                    pop,
   output logic                    full,
   output logic                    empty,
   output rlcc_pkg::close_rec_type head
);
   import rlcc_pkg::*;

   close_rec_type     mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      full  = (count_ff == QCNT_W'(QDEPTH));
      empty = (count_ff == '0);
      head  = mem_ff[rd_ptr_ff];

      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue read while empty");
   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0])
      else $error("queue pointers disagree with fill count");

endmodule

FILE: hw/rtl/rlcc_back.sv
`timescale 1ns / 1ps
module rlcc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  rlcc_pkg::close_rec_type       q_head,
   output logic                          q_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [rlcc_pkg::CHAR_W-1:0]   rsp_char,
   output logic                          rsp_last,
   output logic [rlcc_pkg::LEN_W-1:0]    rsp_length
);
   import rlcc_pkg::*;

   phase_type         phase_ff, phase_in;
   logic              sel_b_ff, sel_b_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  total_ff, total_in;

   logic              out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic              out_last_ff, out_last_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;

   logic              advance;
   logic              on_a;
   logic [CHAR_W-1:0] run_sym;
   logic [CNT_W-1:0]  run_cnt;
   logic              multi;
   logic [IDX_W-1:0]  top_idx;
   logic              run_done;
   logic [3:0]        digit;
   logic [LEN_W-1:0]  length;
   logic              emit_last;

   // Index of the most significant nonzero digit.
   function automatic logic [IDX_W-1:0] top_digit(input logic [CNT_W-1:0] cnt);
      logic [IDX_W-1:0] res;
      res = '0;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (cnt[4*i +: 4] != 4'd0) begin
            res = IDX_W'(i);
         end
      end
      return res;
   endfunction

   always_comb begin
      advance = !q_empty && (!out_valid_ff || rsp_pop);
      on_a    = !sel_b_ff && q_head.a_valid;
      run_sym = on_a ? q_head.a_sym : q_head.b_sym;
      run_cnt = on_a ? q_head.a_cnt : q_head.b_cnt;
      multi   = (run_cnt > CNT_ONE);
      top_idx = top_digit(run_cnt);
      digit   = run_cnt[{idx_ff, 2'b00} +: 4];
      length  = (total_ff == LEN_MAX) ? total_ff : total_ff + LEN_W'(1);

      phase_in    = phase_ff;
      idx_in      = idx_ff;
      sel_b_in    = sel_b_ff;
      q_pop       = 1'b0;
      out_char_in = out_char_ff;
      run_done    = 1'b0;

      case (phase_ff)
         PH_SYM: begin
            out_char_in = run_sym;
            run_done    = !multi;
            if (advance && multi) begin
               phase_in = PH_DIGIT;
               idx_in   = top_idx;
            end
         end
         PH_DIGIT: begin
            out_char_in = ASCII_ZERO + CHAR_W'(digit);
            run_done    = (idx_ff == '0);
            if (advance && !run_done) begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         default: begin
            out_char_in = run_sym;
            run_done    = 1'b1;
         end
      endcase

      // Only the final run carries the end-of-stream flag.
      emit_last = !on_a && run_done;

      if (advance && run_done) begin
         phase_in = PH_SYM;
         if (on_a && q_head.b_valid) begin
            sel_b_in = 1'b1;
         end else begin
            sel_b_in = 1'b0;
            q_pop    = 1'b1;
         end
      end

      total_in     = total_ff;
      out_last_in  = out_last_ff;
      out_len_in   = out_len_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (advance) begin
         out_valid_in = 1'b1;
         out_last_in  = emit_last;
         out_len_in   = length;
         total_in     = emit_last ? '0 : length;
      end else begin
         out_char_in = out_char_ff;
      end

      rsp_empty  = !out_valid_ff;
      rsp_char   = out_char_ff;
      rsp_last   = out_last_ff;
      rsp_length = out_len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYM;
         sel_b_ff     <= 1'b0;
         idx_ff       <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sel_b_ff     <= sel_b_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_len_ff  <= out_len_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (advance && emit_last) |=> (total_ff == '0))
      else $error("stream length not cleared after final symbol");
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIGIT) |-> multi)
      else $error("digits sent for a run of length one");
   assert property (@(posedge clock) disable iff (reset)
      sel_b_ff |-> (q_head.b_valid && !q_empty))
      else $error("second run selected without a final run pending");

endmodule

FILE: hw/rtl/run_length_char_compressor.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle while the close queue has room. The back end sends one
// symbol per cycle while the receiver keeps popping: a closed run gives its character, plus
// one symbol per count digit when its count is above one, and one request may close two runs.
// Reset (synchronous, active high) discards any open run, empties the queue and the result
// register, and starts a fresh stream with a compressed length of zero.
module run_length_char_compressor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [rlcc_pkg::CHAR_W-1:0]   req_char,
   input  logic                          req_last,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [rlcc_pkg::CHAR_W-1:0]   rsp_char,
   output logic                          rsp_last,
   output logic [rlcc_pkg::LEN_W-1:0]    rsp_length
);
   import rlcc_pkg::*;

   // The front end tracks the open run and turns each request into at most one
   // close record: the run that a new character or a full count ended, and the
   // final run when the request marks the end of the stream.
   logic          q_push;
   close_rec_type q_rec;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;
   close_rec_type q_head;

   // The front end stalls only when the close queue is full.
   assign req_full = q_full;

   rlcc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_char (req_char),
      .req_last (req_last),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_rec    (q_rec)
   );

   // A short queue decouples run tracking from symbol expansion, so a long
   // run count being spelled out does not immediately back up the input.
   rlcc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_rec),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   // The back end expands each run of a record into its character followed, for a
   // count above one, by its decimal digits, keeps the running length, and holds one result in
   // an output register that is refilled in the same cycle it is popped if a record waits.
   rlcc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_char   (rsp_char),
      .rsp_last   (rsp_last),
      .rsp_length (rsp_length)
   );

endmodule

FILE: tb/compressed_stream_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the compressor, predicts the compressed symbols of
// every accepted request and compares each popped result against them.
module compressed_stream_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  logic                        req_full,
   input  logic [rlcc_pkg::CHAR_W-1:0] req_char,
   input  logic                        req_last,
   input  logic                        rsp_empty,
   input  logic                        rsp_pop,
   input  logic [rlcc_pkg::CHAR_W-1:0] rsp_char,
   input  logic                        rsp_last,
   input  logic [rlcc_pkg::LEN_W-1:0]  rsp_length,
   output int                          errors,
   output int                          pending
);
   import rlcc_pkg::*;

   localparam logic [CNT_W-1:0] CNT_FULL = {COUNT_DIGITS{4'h9}};

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic [LEN_W-1:0]  len;
   } compressed_symbol_type;

   compressed_symbol_type expected_symbols[$];

   logic [CHAR_W-1:0] run_sym;
   logic [CNT_W-1:0]  run_cnt;
   logic              run_open;
   logic [LEN_W-1:0]  emitted;
   int                fail_count;

   function automatic void emit_symbol(input logic [CHAR_W-1:0] sym);
      compressed_symbol_type s;
      if (emitted != LEN_MAX) emitted = emitted + 1'b1;
      s.ch = sym;
      s.last = 1'b0;
      s.len = emitted;
      expected_symbols.push_back(s);
   endfunction

   // Emits the run's character, then, for a count above one, its count digits without leading zeros.
   function automatic void close_run();
      int top;
      top = 0;
      emit_symbol(run_sym);
      if (run_cnt > CNT_ONE) begin
         for (int i = 0; i < COUNT_DIGITS; i++) begin
            if (run_cnt[4*i +: 4] != 4'd0) top = i;
         end
         for (int i = top; i >= 0; i--) begin
            emit_symbol(ASCII_ZERO + CHAR_W'(run_cnt[4*i +: 4]));
         end
      end
      run_open = 1'b0;
   endfunction

   function automatic logic [CNT_W-1:0] bcd_step(input logic [CNT_W-1:0] cnt);
      logic [CNT_W-1:0] r;
      logic             carry;
      r = cnt;
      carry = 1'b1;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (carry) begin
            if (r[4*i +: 4] == 4'd9) begin
               r[4*i +: 4] = 4'd0;
            end else begin
               r[4*i +: 4] = r[4*i +: 4] + 4'd1;
               carry = 1'b0;
            end
         end
      end
      return r;
   endfunction

   function automatic void predict_compressed(input logic [CHAR_W-1:0] ch,
                                              input logic last);
      compressed_symbol_type s;
      if (run_open && (ch != run_sym || run_cnt == CNT_FULL)) close_run();
      if (run_open) begin
         run_cnt = bcd_step(run_cnt);
      end else begin
         run_sym = ch;
         run_cnt = CNT_ONE;
         run_open = 1'b1;
      end
      if (last) begin
         close_run();
         s = expected_symbols.pop_back();
         s.last = 1'b1;
         expected_symbols.push_back(s);
         emitted = '0;
      end
   endfunction

   always @(posedge clock) begin
      compressed_symbol_type want;
      if (reset) begin
         run_sym = '0;
         run_cnt = '0;
         run_open = 1'b0;
         emitted = '0;
         expected_symbols.delete();
      end else begin
         if (req_push && !req_full) predict_compressed(req_char, req_last);
         if (rsp_pop && !rsp_empty) begin
            if (expected_symbols.size() == 0) begin
               $error("rsp: unexpected symbol, char %02h last %0d length %0d",
                      rsp_char, rsp_last, rsp_length);
               fail_count++;
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_char !== want.ch) begin
                  $error("rsp_char: expected %02h, actual %02h", want.ch, rsp_char);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("rsp_last: expected %0d, actual %0d", want.last, rsp_last);
                  fail_count++;
               end
               if (rsp_length !== want.len) begin
                  $error("rsp_length: expected %0d, actual %0d", want.len, rsp_length);
                  fail_count++;
               end
            end
         end
      end
      pending <= expected_symbols.size();
      errors <= fail_count;
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the compressor testbench. It makes the clock and the reset, drives the
// request channel, pops the result channel, and gives the verdict. All
// prediction and comparison lives in the checker instantiated next to the block.
module testbench;
   import rlcc_pkg::*;

   // A generous ceiling on the whole run. The directed requests and four phases of at
   // least a hundred random requests each, even if each one caused the most results under
   // the heaviest stalls, leave a wide margin below it on any correct run.
   localparam int CYCLE_LIMIT = 200_000;

   // Cycles to wait once nothing is expected any more, so that a late result, or one
   // from a back end still busy spelling out the runs of one request, can show up.
   localparam int TAIL_CYCLES = 2 * (COUNT_DIGITS + 2) + 4;

   // Minimum number of random requests per idling phase, four phases in all.
   localparam int PHASE_REQUESTS = 100;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   logic [CHAR_W-1:0] req_char = '0;
   logic              req_last = 1'b0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   logic [CHAR_W-1:0] rsp_char;
   logic              rsp_last;
   logic [LEN_W-1:0]  rsp_length;

   int errors;
   int pending;
   int cycle_count = 0;

   // Chance out of a hundred that the sender idles or the receiver stalls in
   // a given cycle.
   int idle_pct = 0;
   int stall_pct = 0;

   always #2 clock = ~clock;

   run_length_char_compressor dut (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_char   (req_char),
      .req_last   (req_last),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_char   (rsp_char),
      .rsp_last   (rsp_last),
      .rsp_length (rsp_length)
   );

   compressed_stream_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_char   (req_char),
      .req_last   (req_last),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_char   (rsp_char),
      .rsp_last   (rsp_last),
      .rsp_length (rsp_length),
      .errors     (errors),
      .pending    (pending)
   );

   // The receiver decides every cycle whether to pop, so stalls land on the
   // character as well as on any digit of a count.
   always @(posedge clock) begin
      rsp_pop <= !reset && ($urandom_range(0, 99) >= stall_pct);
   end

   // Watchdog: a hung block ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // Offers one character and holds it until the block takes it. The value of
   // req_full read right after the edge is the one the block saw at that edge,
   // so leaving the loop means the request was accepted there.
   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_char <= ch;
      req_last <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // Stops sending until every predicted symbol has been popped.
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Sends one random stream. Most streams are well formed: a few runs of
   // characters, mostly from a small alphabet so that runs repeat and merge,
   // closed by a flagged last character. Some streams are left open so that
   // the next one continues them, and now and then a few loose requests with
   // a random last flag are sent as noise.
   task automatic send_random_stream(inout int sent);
      int                num_runs;
      int                run_len;
      int                pick;
      logic              leave_open;
      logic [CHAR_W-1:0] ch;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            send_char(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            sent = sent + 1;
         end
      end else begin
         num_runs = $urandom_range(1, 6);
         leave_open = ($urandom_range(0, 9) == 0);
         for (int r = 0; r < num_runs; r++) begin
            if ($urandom_range(0, 99) < 60) ch = 8'h61 + CHAR_W'($urandom_range(0, 2));
            else ch = CHAR_W'($urandom_range(0, 255));
            // Mostly short runs, some up to fifteen, a few up to 130, so counts have one to three digits.
            pick = $urandom_range(0, 99);
            if (pick < 70) run_len = $urandom_range(1, 3);
            else if (pick < 95) run_len = $urandom_range(4, 15);
            else run_len = $urandom_range(16, 130);
            for (int k = 0; k < run_len; k++) begin
               send_char(ch, (r == num_runs - 1) && (k == run_len - 1) && !leave_open);
               sent = sent + 1;
            end
         end
      end
   endtask

   initial begin
      int sent;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, no idling. Single-character streams at the extremes of
      // the character range; each flagged request also starts a new stream.
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      // A run of two followed by a run of one that ends the stream.
      send_char("a", 1'b0);
      send_char("a", 1'b0);
      send_char("b", 1'b1);
      // A run of ten: its count has a zero digit.
      for (int i = 0; i < 10; i++) send_char("x", i == 9);
      // Alternating bit patterns, every run of length one.
      send_char(8'h55, 1'b0);
      send_char(8'hAA, 1'b0);
      send_char(8'h55, 1'b0);
      send_char(8'hAA, 1'b1);
      drain();

      // Random part in four idling phases, with a full drain between them.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         sent = 0;
         while (sent < PHASE_REQUESTS) send_random_stream(sent);
         drain();
      end

      // Let any late or extra symbol show up before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
